>>> hdl/mtss_pkg.sv
// Package for the multimode test signal synthesizer.
// Holds sizes, register indexes, mode codes, the configuration struct and the
// quarter-wave sine table builder. No dependencies.
package mtss_pkg;

  localparam int SYMBOL_SAMPLES  = 30720;
  localparam int FRAME_SAMPLES   = 2880000;
  localparam int TX_SAMPLES      = 2426880;
  localparam int SPACING_STEP    = 139810;
  localparam int SINE_TABLE_BITS = 10;
  localparam int SAMPLE_BITS     = 16;

  localparam int QBITS = SINE_TABLE_BITS - 2;
  localparam int QSIZE = (1 << QBITS) + 1;
  localparam int SYMW  = $clog2(SYMBOL_SAMPLES + 1);

  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [31:0] TONE1_RESET  = 32'd751619277;
  localparam logic [31:0] TONE2_RESET  = 32'd1571958030;

  localparam logic [17:0] FORMANT_RATIO [3] = '{18'd65536, 18'd111411, 18'd190054};
  localparam logic [15:0] FORMANT_LEVEL [3] = '{16'd32768, 16'd18022, 16'd8192};

  // register indexes
  localparam logic [2:0] REG_MODE      = 3'd0;
  localparam logic [2:0] REG_AMPLITUDE = 3'd1;
  localparam logic [2:0] REG_OFFSET    = 3'd2;
  localparam logic [2:0] REG_TONE      = 3'd3;
  localparam logic [2:0] REG_SYLLABLE  = 3'd4;
  localparam logic [2:0] REG_QSB_STEP  = 3'd5;
  localparam logic [2:0] REG_QSB_FLOOR = 3'd6;
  localparam logic [2:0] REG_FM_DEV    = 3'd7;

  // mode codes
  localparam logic [2:0] MODE_OFF     = 3'd0;
  localparam logic [2:0] MODE_CARRIER = 3'd1;
  localparam logic [2:0] MODE_AM      = 3'd2;
  localparam logic [2:0] MODE_USB     = 3'd3;
  localparam logic [2:0] MODE_LSB     = 3'd4;
  localparam logic [2:0] MODE_FM      = 3'd5;
  localparam logic [2:0] MODE_FSK     = 3'd6;
  localparam logic [2:0] MODE_OFF_ALT = 3'd7;

  typedef struct packed {
    logic [2:0]  mode;
    logic [14:0] amplitude;
    logic [31:0] offset_step;
    logic [30:0] tone_step;
    logic [30:0] syllable_step;
    logic [30:0] qsb_step;
    logic [14:0] qsb_floor;
    logic [30:0] fm_dev_step;
  } cfg_t;

  typedef logic [14:0] qtab_t [QSIZE];

  // Q16 quarter-wave polynomial, scaled to Q1.15 magnitude
  function automatic qtab_t build_qtab();
    qtab_t tab;
    longint unsigned x, x2, t, s, v;
    for (int r = 0; r < QSIZE; r++) begin
      x  = longint'(r) << (16 - QBITS);
      x2 = (x * x) >> 16;
      t  = 64'd42047 - ((x2 * 64'd4639) >> 16);
      t  = 64'd102944 - ((x2 * t) >> 16);
      s  = (x * t) >> 16;
      v  = (s * 64'd32767 + 64'd32768) >> 16;
      tab[r] = 15'(v);
    end
    return tab;
  endfunction

endpackage

>>> hdl/mtss_sine.sv
// Registered sine lookup: top SINE_TABLE_BITS of a 32-bit phase select a
// quarter-wave constant table entry. Depends on mtss_pkg.
module mtss_sine (
  input  logic                clk_i,
  input  logic [31:0]         phase_i,
  output logic signed [15:0]  sin_o
);
  import mtss_pkg::*;

  localparam qtab_t QTAB = build_qtab();

  logic [SINE_TABLE_BITS-1:0] k;
  logic [1:0]                 quad;
  logic [QBITS-1:0]           r;
  logic [QBITS:0]             idx;
  logic [14:0]                mag;
  logic signed [15:0]         sin_q;

  assign k    = phase_i[31 -: SINE_TABLE_BITS];
  assign quad = k[SINE_TABLE_BITS-1 -: 2];
  assign r    = k[QBITS-1:0];
  // mirror odd quadrants
  assign idx  = quad[0] ? ((QBITS+1)'(1 << QBITS) - {1'b0, r}) : {1'b0, r};
  assign mag  = QTAB[idx];

  always_ff @(posedge clk_i) begin
    sin_q <= quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

  assign sin_o = sin_q;

endmodule

>>> hdl/mtss_mul.sv
// Shared registered multiplier, 33 x 19 signed. Depends on nothing.
module mtss_mul (
  input  logic               clk_i,
  input  logic signed [32:0] a_i,
  input  logic signed [18:0] b_i,
  output logic signed [51:0] p_o
);
  logic signed [51:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= 52'(a_i) * 52'(b_i);
  end

  assign p_o = p_q;

endmodule

>>> hdl/mtss_core.sv
// Sequencer of the synthesizer: phase accumulators, frame counters and one
// item at a time through the shared sine table and multiplier, plus the
// output register. Depends on mtss_pkg, mtss_sine, mtss_mul.
module mtss_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  mtss_pkg::cfg_t                 cfg_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [mtss_pkg::SAMPLE_BITS-1:0] in_i_i,
  input  logic signed [mtss_pkg::SAMPLE_BITS-1:0] in_q_i,
  input  logic                           in_last_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [mtss_pkg::SAMPLE_BITS-1:0] out_i_o,
  output logic signed [mtss_pkg::SAMPLE_BITS-1:0] out_q_o,
  output logic                           out_last_o,
  output logic                           out_active_o
);
  import mtss_pkg::*;

  localparam int SHL = (SAMPLE_BITS >= 16) ? SAMPLE_BITS - 16 : 0;
  localparam int SHR = (SAMPLE_BITS < 16) ? 16 - SAMPLE_BITS : 0;
  localparam int SW  = SAMPLE_BITS + 22;
  localparam logic signed [SW-1:0] SAT_HI = SW'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);

  typedef enum logic [4:0] {
    S_IDLE, S_FADE, S_GAIN, S_AMP, S_AMPR, S_ENV0, S_ENV1, S_ENV2,
    S_AM0, S_AM1, S_AM2, S_AM3,
    S_SSB_PH, S_SSB_C, S_SSB_S, S_SSB_I, S_SSB_SC, S_SSB_BI, S_SSB_BQ,
    S_FM0, S_FM1, S_PM_COS, S_PM_SIN, S_PM_BQ,
    S_MIX0, S_MIX1, S_MIX2, S_MIX3, S_MIX4, S_MIX5, S_DONE
  } state_e;

  state_e state_q, state_d;

  logic signed [SAMPLE_BITS-1:0] xi_q, xi_d, xq_q, xq_d;
  logic last_q, last_d, active_q, active_d;
  logic [14:0] gain_q, gain_d, amp_q, amp_d, env_q, env_d;
  logic signed [17:0] bi_q, bi_d, bq_q, bq_d;
  logic signed [33:0] re_q, re_d, im_q, im_d;
  logic [1:0] k_q, k_d;
  logic signed [15:0] ci_q, ci_d, si_q, si_d;
  logic signed [34:0] acc_q, acc_d;
  logic signed [19:0] mi_q, mi_d, mq_q, mq_d;
  logic [31:0] carrier_q, carrier_d, fade_q, fade_d, envph_q, envph_d;
  logic [31:0] tone_q [3];
  logic [31:0] tone_d [3];
  logic [21:0] frame_q, frame_d;
  logic [SYMW-1:0] symcnt_q, symcnt_d;
  logic [2:0] symidx_q, symidx_d;

  logic out_valid_q, out_valid_d, out_last_q, out_last_d, out_active_q, out_active_d;
  logic signed [SAMPLE_BITS-1:0] out_i_q, out_i_d, out_q_q, out_q_d;

  logic [31:0]        sin_ph;
  logic signed [15:0] sin_val;
  logic signed [32:0] mul_a;
  logic signed [18:0] mul_b;
  logic signed [51:0] p;

  logic [31:0]        ph_new;
  logic [21:0]        frame_nx;
  logic [SYMW-1:0]    symcnt_nx;
  logic [14:0]        s_half;
  logic signed [16:0] am_m;
  logic signed [34:0] mix_sum;
  logic signed [SW-1:0] ext_i, ext_q, sum_i, sum_q;

  mtss_sine u_sine (
    .clk_i  (clk_i),
    .phase_i(sin_ph),
    .sin_o  (sin_val)
  );

  mtss_mul u_mul (
    .clk_i(clk_i),
    .a_i  (mul_a),
    .b_i  (mul_b),
    .p_o  (p)
  );

  assign in_stall_o = (state_q != S_IDLE);

  // contribution scaled to the sample width, added and clipped
  always_comb begin
    ext_i = (SW'(mi_q) <<< SHL) >>> SHR;
    ext_q = (SW'(mq_q) <<< SHL) >>> SHR;
    sum_i = ext_i + SW'(xi_q);
    sum_q = ext_q + SW'(xq_q);
    if (sum_i > SAT_HI) sum_i = SAT_HI;
    if (sum_i < SAT_LO) sum_i = SAT_LO;
    if (sum_q > SAT_HI) sum_q = SAT_HI;
    if (sum_q < SAT_LO) sum_q = SAT_LO;
  end

  always_comb begin
    state_d   = state_q;
    xi_d = xi_q; xq_d = xq_q; last_d = last_q; active_d = active_q;
    gain_d = gain_q; amp_d = amp_q; env_d = env_q;
    bi_d = bi_q; bq_d = bq_q; re_d = re_q; im_d = im_q; k_d = k_q;
    ci_d = ci_q; si_d = si_q; acc_d = acc_q; mi_d = mi_q; mq_d = mq_q;
    carrier_d = carrier_q; fade_d = fade_q; envph_d = envph_q;
    tone_d = tone_q;
    frame_d = frame_q; symcnt_d = symcnt_q; symidx_d = symidx_q;
    out_valid_d  = out_valid_q & out_stall_i;
    out_i_d = out_i_q; out_q_d = out_q_q;
    out_last_d = out_last_q; out_active_d = out_active_q;
    sin_ph = carrier_q;
    mul_a  = '0;
    mul_b  = '0;
    ph_new = '0;
    frame_nx  = frame_q + 22'd1;
    symcnt_nx = symcnt_q + SYMW'(1);
    s_half = 15'((17'(sin_val) + 17'sd32767) >>> 1);
    am_m   = 17'sd32768 + 17'($signed(p[30:15]));
    mix_sum = acc_q + p[34:0];

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          xi_d = in_i_i; xq_d = in_q_i; last_d = in_last_i;
          active_d = 1'b1;
          if (cfg_i.mode == MODE_OFF || cfg_i.mode == MODE_OFF_ALT) begin
            active_d = 1'b0;
            mi_d = '0; mq_d = '0;
            state_d = S_DONE;
          end else if (cfg_i.qsb_step != '0) begin
            fade_d = fade_q + 32'(cfg_i.qsb_step);
            sin_ph = fade_d;
            state_d = S_FADE;
          end else begin
            gain_d = 15'h7FFF;
            state_d = S_AMP;
          end
        end
      end
      S_FADE: begin
        mul_a = 33'(15'h7FFF - cfg_i.qsb_floor);
        mul_b = 19'(s_half);
        state_d = S_GAIN;
      end
      S_GAIN: begin
        gain_d = cfg_i.qsb_floor + p[29:15];
        state_d = S_AMP;
      end
      S_AMP: begin
        mul_a = 33'(cfg_i.amplitude);
        mul_b = 19'(gain_q);
        state_d = S_AMPR;
      end
      S_AMPR: begin
        amp_d = p[29:15];
        case (cfg_i.mode)
          MODE_CARRIER: begin
            bi_d = 18'(p[29:15]);
            bq_d = '0;
            state_d = S_MIX0;
          end
          MODE_FSK: begin
            if (frame_nx >= 22'(FRAME_SAMPLES)) begin
              frame_d = '0; symcnt_d = '0; symidx_d = '0;
            end else begin
              frame_d = frame_nx;
              if (symcnt_nx == SYMW'(SYMBOL_SAMPLES)) begin
                symcnt_d = '0;
                symidx_d = symidx_q + 3'd1;
              end else begin
                symcnt_d = symcnt_nx;
              end
            end
            if (frame_d < 22'(TX_SAMPLES)) begin
              ph_new = tone_q[0] + 32'(cfg_i.tone_step)
                       + 32'(symidx_d) * 32'(SPACING_STEP);
              tone_d[0] = ph_new;
              sin_ph = ph_new + QUARTER_TURN;
              state_d = S_PM_COS;
            end else begin
              // silent part of the frame: carrier still advances
              active_d = 1'b0;
              bi_d = '0; bq_d = '0;
              state_d = S_MIX0;
            end
          end
          default: begin
            envph_d = envph_q + 32'(cfg_i.syllable_step);
            sin_ph = envph_d;
            state_d = S_ENV0;
          end
        endcase
      end
      S_ENV0: begin
        mul_a = 33'(s_half);
        mul_b = 19'(s_half);
        state_d = S_ENV1;
      end
      S_ENV1: begin
        mul_a = 33'(15'd27853);
        mul_b = 19'(p[29:15]);
        state_d = S_ENV2;
      end
      S_ENV2: begin
        env_d = 15'd4915 + p[29:15];
        case (cfg_i.mode)
          MODE_AM: begin
            tone_d[0] = tone_q[0] + 32'(cfg_i.tone_step);
            sin_ph = tone_d[0];
            state_d = S_AM0;
          end
          MODE_FM: begin
            tone_d[0] = tone_q[0] + 32'(cfg_i.tone_step);
            sin_ph = tone_d[0];
            mul_a = 33'(cfg_i.fm_dev_step);
            mul_b = 19'(env_d);
            state_d = S_FM0;
          end
          default: begin
            k_d = 2'd0;
            re_d = '0; im_d = '0;
            mul_a = 33'(cfg_i.tone_step);
            mul_b = 19'(FORMANT_RATIO[0]);
            state_d = S_SSB_PH;
          end
        endcase
      end
      S_AM0: begin
        mul_a = 33'(sin_val);
        mul_b = 19'(env_q);
        state_d = S_AM1;
      end
      S_AM1: begin
        mul_a = 33'(15'd22938);
        mul_b = 19'($signed(p[30:15]));
        state_d = S_AM2;
      end
      S_AM2: begin
        mul_a = 33'(amp_q);
        mul_b = 19'(am_m);
        state_d = S_AM3;
      end
      S_AM3: begin
        bi_d = p[32:15];
        bq_d = '0;
        state_d = S_MIX0;
      end
      S_SSB_PH: begin
        ph_new = tone_q[k_q] + p[47:16];
        tone_d[k_q] = ph_new;
        sin_ph = ph_new + QUARTER_TURN;
        state_d = S_SSB_C;
      end
      S_SSB_C: begin
        mul_a = 33'(FORMANT_LEVEL[k_q]);
        mul_b = 19'(sin_val);
        sin_ph = tone_q[k_q];
        state_d = S_SSB_S;
      end
      S_SSB_S: begin
        re_d = re_q + 34'(p[33:0]);
        mul_a = 33'(FORMANT_LEVEL[k_q]);
        mul_b = 19'(sin_val);
        state_d = S_SSB_I;
      end
      S_SSB_I: begin
        im_d = im_q + 34'(p[33:0]);
        if (k_q != 2'd2) begin
          k_d = k_q + 2'd1;
          mul_a = 33'(cfg_i.tone_step);
          mul_b = 19'(FORMANT_RATIO[k_d]);
          state_d = S_SSB_PH;
        end else begin
          mul_a = 33'(amp_q);
          mul_b = 19'(env_q);
          state_d = S_SSB_SC;
        end
      end
      S_SSB_SC: begin
        amp_d = {1'b0, p[29:16]}; // hold scale
        mul_a = 33'($signed(re_q[33:15]));
        mul_b = 19'({1'b0, p[29:16]});
        state_d = S_SSB_BI;
      end
      S_SSB_BI: begin
        bi_d = p[32:15];
        mul_a = 33'($signed(im_q[33:15]));
        mul_b = 19'(amp_q);
        state_d = S_SSB_BQ;
      end
      S_SSB_BQ: begin
        bq_d = (cfg_i.mode == MODE_LSB) ? -p[32:15] : p[32:15];
        state_d = S_MIX0;
      end
      S_FM0: begin
        mul_a = 33'({1'b0, p[46:15]});
        mul_b = 19'(sin_val);
        state_d = S_FM1;
      end
      S_FM1: begin
        ph_new = tone_q[1] + p[46:15];
        tone_d[1] = ph_new;
        sin_ph = ph_new + QUARTER_TURN;
        state_d = S_PM_COS;
      end
      S_PM_COS: begin
        mul_a = 33'(amp_q);
        mul_b = 19'(sin_val);
        sin_ph = (cfg_i.mode == MODE_FM) ? tone_q[1] : tone_q[0];
        state_d = S_PM_SIN;
      end
      S_PM_SIN: begin
        bi_d = p[32:15];
        mul_a = 33'(amp_q);
        mul_b = 19'(sin_val);
        state_d = S_PM_BQ;
      end
      S_PM_BQ: begin
        bq_d = p[32:15];
        state_d = S_MIX0;
      end
      S_MIX0: begin
        sin_ph = carrier_q + QUARTER_TURN;
        state_d = S_MIX1;
      end
      S_MIX1: begin
        ci_d = sin_val;
        sin_ph = carrier_q;
        mul_a = 33'(bi_q);
        mul_b = 19'(sin_val);
        state_d = S_MIX2;
      end
      S_MIX2: begin
        si_d = sin_val;
        acc_d = p[34:0];
        mul_a = 33'(bq_q);
        mul_b = 19'(sin_val);
        state_d = S_MIX3;
      end
      S_MIX3: begin
        acc_d = acc_q - p[34:0];
        mul_a = 33'(bi_q);
        mul_b = 19'(si_q);
        state_d = S_MIX4;
      end
      S_MIX4: begin
        mi_d = acc_q[34:15];
        acc_d = p[34:0];
        mul_a = 33'(bq_q);
        mul_b = 19'(ci_q);
        state_d = S_MIX5;
      end
      S_MIX5: begin
        mq_d = mix_sum[34:15];
        carrier_d = carrier_q + cfg_i.offset_step;
        state_d = S_DONE;
      end
      S_DONE: begin
        // wait for the output register to free up
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_i_d      = SAMPLE_BITS'(sum_i);
          out_q_d      = SAMPLE_BITS'(sum_q);
          out_last_d   = last_q;
          out_active_d = active_q;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      carrier_q   <= '0;
      fade_q      <= '0;
      envph_q     <= '0;
      tone_q[0]   <= '0;
      tone_q[1]   <= TONE1_RESET;
      tone_q[2]   <= TONE2_RESET;
      frame_q     <= '0;
      symcnt_q    <= '0;
      symidx_q    <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      carrier_q   <= carrier_d;
      fade_q      <= fade_d;
      envph_q     <= envph_d;
      tone_q      <= tone_d;
      frame_q     <= frame_d;
      symcnt_q    <= symcnt_d;
      symidx_q    <= symidx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    xi_q <= xi_d; xq_q <= xq_d; last_q <= last_d; active_q <= active_d;
    gain_q <= gain_d; amp_q <= amp_d; env_q <= env_d;
    bi_q <= bi_d; bq_q <= bq_d; re_q <= re_d; im_q <= im_d; k_q <= k_d;
    ci_q <= ci_d; si_q <= si_d; acc_q <= acc_d; mi_q <= mi_d; mq_q <= mq_d;
    out_i_q <= out_i_d; out_q_q <= out_q_d;
    out_last_q <= out_last_d; out_active_q <= out_active_d;
  end

  assign out_valid_o  = out_valid_q;
  assign out_i_o      = out_i_q;
  assign out_q_o      = out_q_q;
  assign out_last_o   = out_last_q;
  assign out_active_o = out_active_q;

endmodule

>>> hdl/multimode_test_signal_synth.sv
// Top level of the multimode test signal synthesizer: configuration registers
// and the sequencer core. Depends on mtss_pkg and mtss_core.
//
// Adds one synthetic station (carrier, AM, USB, LSB, FM or 8-tone FSK, with
// optional slow fading) to each incoming I/Q transaction and saturates the
// sum. A sample is worked one step at a time through a single shared 33x19
// multiplier and one registered sine table; off mode goes straight to the
// output step, and the other modes take more steps, in rising order:
// carrier and the silent part of the FSK frame, FSK, AM, FM, USB/LSB. Fading
// adds the S_FADE and S_GAIN states. The result is registered as the
// sequencer returns to idle, where the next input can be taken. The input
// stalls while a sample is in work; a finished sample waits in the output
// register while the next one is taken, and a sample that finds the output
// register still full waits in its last step. Write configuration only when
// idle.
module multimode_test_signal_synth (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_we_i,
  input  logic [2:0]                              cfg_index_i,
  input  logic [31:0]                             cfg_data_i,
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic signed [mtss_pkg::SAMPLE_BITS-1:0] in_i_i,
  input  logic signed [mtss_pkg::SAMPLE_BITS-1:0] in_q_i,
  input  logic                                    in_last_i,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic signed [mtss_pkg::SAMPLE_BITS-1:0] out_i_o,
  output logic signed [mtss_pkg::SAMPLE_BITS-1:0] out_q_o,
  output logic                                    out_last_o,
  output logic                                    out_active_o
);
  import mtss_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode          <= MODE_OFF;
      cfg_q.amplitude     <= 15'd16384;
      cfg_q.offset_step   <= '0;
      cfg_q.tone_step     <= '0;
      cfg_q.syllable_step <= '0;
      cfg_q.qsb_step      <= '0;
      cfg_q.qsb_floor     <= 15'd32767;
      cfg_q.fm_dev_step   <= 31'd55924053;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_MODE:      cfg_q.mode          <= cfg_data_i[2:0];
        REG_AMPLITUDE: cfg_q.amplitude     <= cfg_data_i[14:0];
        REG_OFFSET:    cfg_q.offset_step   <= cfg_data_i;
        REG_TONE:      cfg_q.tone_step     <= cfg_data_i[30:0];
        REG_SYLLABLE:  cfg_q.syllable_step <= cfg_data_i[30:0];
        REG_QSB_STEP:  cfg_q.qsb_step      <= cfg_data_i[30:0];
        REG_QSB_FLOOR: cfg_q.qsb_floor     <= cfg_data_i[14:0];
        REG_FM_DEV:    cfg_q.fm_dev_step   <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  mtss_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_i_i      (in_i_i),
    .in_q_i      (in_q_i),
    .in_last_i   (in_last_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_i_o     (out_i_o),
    .out_q_o     (out_q_o),
    .out_last_o  (out_last_o),
    .out_active_o(out_active_o)
  );

endmodule
